FILE: sv/bhpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared constants, types and the heap order compare of the priority queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

  localparam int unsigned DEPTH        = 1024;
  localparam int unsigned KEY_BITS     = 32;
  localparam int unsigned PAYLOAD_BITS = 16;
  localparam int unsigned ADDR_W       = $clog2(DEPTH);
  localparam int unsigned CNT_W        = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W        = ADDR_W + 2;
  localparam int unsigned ENTRY_W      = KEY_BITS + PAYLOAD_BITS;
  localparam int unsigned PADDR_W      = 3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam logic REG_MAX_FIRST = 1'b0;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [CNT_W-1:0]        occupancy;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } ram_req_t;

  // true when key a must sit above key b
  function automatic logic comes_first(input logic max_first,
                                       input logic [KEY_BITS-1:0] a,
                                       input logic [KEY_BITS-1:0] b);
    comes_first = max_first ? (a > b) : (a < b);
  endfunction

endpackage
`default_nettype wire

FILE: sv/bhpq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bhpq_ram
// Generic synchronous RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module bhpq_ram #(
  parameter int unsigned DATA_W = 48,
  parameter int unsigned ADDR_W = 10
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_a_i,
  input  wire logic [ADDR_W-1:0] raddr_b_i,
  output logic      [DATA_W-1:0] rdata_a_o,
  output logic      [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule
`default_nettype wire

FILE: sv/bhpq_sift.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bhpq_sift
// Heap sequencer: insert with sift up, remove root with sift down, one tree
// level per cycle over the entry RAM, moving a hole instead of swapping.
// ----------------------------------------------------------------------------
module bhpq_sift (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                max_first_i,
  input  wire logic                                req_valid_i,
  output logic                                     req_ready_o,
  input  wire logic                                req_func_i,
  input  wire bhpq_pkg::entry_t                    req_entry_i,
  output logic                                     res_valid_o,
  input  wire logic                                res_ready_i,
  output bhpq_pkg::result_t                        res_o,
  output bhpq_pkg::ram_req_t                       ram_o,
  input  wire bhpq_pkg::entry_t                    rdata_a_i,
  input  wire bhpq_pkg::entry_t                    rdata_b_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CMP,
    S_RM_RD,
    S_DN_CMP,
    S_PLACE,
    S_DONE
  } state_e;

  state_e                          state_q, state_d;
  logic [bhpq_pkg::CNT_W-1:0]      count_q, count_d;
  logic [bhpq_pkg::ADDR_W-1:0]     idx_q, idx_d;
  bhpq_pkg::entry_t                cur_q, cur_d;
  bhpq_pkg::result_t               res_q, res_d;

  logic [bhpq_pkg::ADDR_W-1:0]     parent;
  logic [bhpq_pkg::IDX_W-1:0]      left_idx, right_idx, pick_idx, next_left;
  logic                            right_ok, pick_right;
  bhpq_pkg::entry_t                pick;

  always_comb begin
    parent     = (idx_q - bhpq_pkg::ADDR_W'(1)) >> 1;
    left_idx   = bhpq_pkg::IDX_W'({idx_q, 1'b1});
    right_idx  = left_idx + bhpq_pkg::IDX_W'(1);
    right_ok   = right_idx < bhpq_pkg::IDX_W'(count_q);
    pick_right = right_ok &&
                 !bhpq_pkg::comes_first(max_first_i, rdata_a_i.key, rdata_b_i.key);
    pick       = pick_right ? rdata_b_i : rdata_a_i;
    pick_idx   = pick_right ? right_idx : left_idx;
    next_left  = bhpq_pkg::IDX_W'({pick_idx[bhpq_pkg::ADDR_W-1:0], 1'b1});
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    cur_d       = cur_q;
    res_d       = res_q;
    ram_o       = '0;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          res_d = '0;
          if (req_func_i == bhpq_pkg::FUNC_INSERT) begin
            if (count_q == bhpq_pkg::CNT_W'(bhpq_pkg::DEPTH)) begin
              res_d.status    = bhpq_pkg::ST_FULL;
              res_d.occupancy = count_q;
              state_d         = S_DONE;
            end else begin
              res_d.status    = bhpq_pkg::ST_OK;
              res_d.occupancy = count_q + bhpq_pkg::CNT_W'(1);
              count_d         = count_q + bhpq_pkg::CNT_W'(1);
              cur_d           = req_entry_i;
              idx_d           = count_q[bhpq_pkg::ADDR_W-1:0];
              if (count_q == '0) begin
                ram_o.we    = 1'b1;
                ram_o.waddr = '0;
                ram_o.wdata = req_entry_i;
                state_d     = S_DONE;
              end else begin
                ram_o.re      = 1'b1;
                ram_o.raddr_a = bhpq_pkg::ADDR_W'((count_q - bhpq_pkg::CNT_W'(1)) >> 1);
                state_d       = S_UP_CMP;
              end
            end
          end else begin
            if (count_q == '0) begin
              res_d.status    = bhpq_pkg::ST_EMPTY;
              res_d.occupancy = count_q;
              state_d         = S_DONE;
            end else begin
              res_d.status    = bhpq_pkg::ST_OK;
              res_d.occupancy = count_q - bhpq_pkg::CNT_W'(1);
              count_d         = count_q - bhpq_pkg::CNT_W'(1);
              ram_o.re        = 1'b1;
              ram_o.raddr_a   = '0;
              ram_o.raddr_b   = bhpq_pkg::ADDR_W'(count_q - bhpq_pkg::CNT_W'(1));
              state_d         = S_RM_RD;
            end
          end
        end
      end

      S_UP_CMP: begin
        ram_o.we = 1'b1;
        ram_o.waddr = idx_q;
        if (bhpq_pkg::comes_first(max_first_i, cur_q.key, rdata_a_i.key)) begin
          ram_o.wdata = rdata_a_i;
          idx_d       = parent;
          if (parent == '0) begin
            state_d = S_PLACE;
          end else begin
            ram_o.re      = 1'b1;
            ram_o.raddr_a = (parent - bhpq_pkg::ADDR_W'(1)) >> 1;
          end
        end else begin
          ram_o.wdata = cur_q;
          state_d     = S_DONE;
        end
      end

      S_RM_RD: begin
        res_d.key     = rdata_a_i.key;
        res_d.payload = rdata_a_i.payload;
        cur_d         = rdata_b_i;
        idx_d         = '0;
        if (count_q == '0) begin
          state_d = S_DONE;
        end else if (count_q == bhpq_pkg::CNT_W'(1)) begin
          ram_o.we    = 1'b1;
          ram_o.waddr = '0;
          ram_o.wdata = rdata_b_i;
          state_d     = S_DONE;
        end else begin
          ram_o.re      = 1'b1;
          ram_o.raddr_a = bhpq_pkg::ADDR_W'(1);
          ram_o.raddr_b = bhpq_pkg::ADDR_W'(2);
          state_d       = S_DN_CMP;
        end
      end

      S_DN_CMP: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = idx_q;
        if (bhpq_pkg::comes_first(max_first_i, pick.key, cur_q.key)) begin
          ram_o.wdata = pick;
          idx_d       = pick_idx[bhpq_pkg::ADDR_W-1:0];
          if (next_left < bhpq_pkg::IDX_W'(count_q)) begin
            ram_o.re      = 1'b1;
            ram_o.raddr_a = next_left[bhpq_pkg::ADDR_W-1:0];
            ram_o.raddr_b = bhpq_pkg::ADDR_W'(next_left + bhpq_pkg::IDX_W'(1));
          end else begin
            state_d = S_PLACE;
          end
        end else begin
          ram_o.wdata = cur_q;
          state_d     = S_DONE;
        end
      end

      S_PLACE: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = idx_q;
        ram_o.wdata = cur_q;
        state_d     = S_DONE;
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      cur_q   <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      cur_q   <= cur_d;
      res_q   <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

FILE: sv/binary_heap_priority_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_unit
// Priority queue of up to 1024 key and payload entries kept as a binary heap.
// ----------------------------------------------------------------------------
// One request is worked on at a time. The new entry of an insert climbs one
// tree level per cycle and the last entry, moved to the root by a remove, sinks
// one level per cycle, each until the entry settles; an insert into an empty
// store or a remove that leaves at most one entry needs no climb or sink.
// The pace is set by the entry RAM: each tree level needs one registered
// read (both children at once on the way down) and one write, overlapped so
// that a level is done per cycle. A new request is taken while the previous
// result waits in the output register. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              func_i,
  input  wire logic [31:0]                       key_i,
  input  wire logic [15:0]                       payload_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [1:0]                        status_o,
  output logic      [31:0]                       out_key_o,
  output logic      [15:0]                       out_payload_o,
  output logic      [10:0]                       occupancy_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [bhpq_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready
);

  logic                max_first_q;
  logic                reg_idx;
  logic                sift_valid, sift_ready;
  bhpq_pkg::entry_t    req_entry, rdata_a, rdata_b;
  bhpq_pkg::result_t   sift_res, out_q;
  bhpq_pkg::ram_req_t  ram_req;
  logic                out_valid_q;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_first_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        bhpq_pkg::REG_MAX_FIRST: max_first_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bhpq_pkg::REG_MAX_FIRST: prdata = {31'b0, max_first_q};
      default:                 prdata = '0;
    endcase
  end

  assign req_entry.key     = key_i;
  assign req_entry.payload = payload_i;

  bhpq_sift u_sift (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_first_i (max_first_q),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_func_i  (func_i),
    .req_entry_i (req_entry),
    .res_valid_o (sift_valid),
    .res_ready_i (sift_ready),
    .res_o       (sift_res),
    .ram_o       (ram_req),
    .rdata_a_i   (rdata_a),
    .rdata_b_i   (rdata_b)
  );

  bhpq_ram #(
    .DATA_W (bhpq_pkg::ENTRY_W),
    .ADDR_W (bhpq_pkg::ADDR_W)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_req.we),
    .waddr_i   (ram_req.waddr),
    .wdata_i   (ram_req.wdata),
    .re_i      (ram_req.re),
    .raddr_a_i (ram_req.raddr_a),
    .raddr_b_i (ram_req.raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // output register
  assign sift_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sift_valid && sift_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sift_valid && sift_ready) begin
      out_q <= sift_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign out_key_o     = out_q.key;
  assign out_payload_o = out_q.payload;
  assign occupancy_o   = out_q.occupancy;

endmodule
`default_nettype wire

FILE: sv/bhpq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bhpq_checker
// Port level checks of the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module bhpq_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  status_o,
  input wire logic [31:0] out_key_o,
  input wire logic [15:0] out_payload_o,
  input wire logic [10:0] occupancy_o
);

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occupancy_o <= 11'(bhpq_pkg::DEPTH))
    else $error("occupancy beyond store depth");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == bhpq_pkg::ST_FULL) |->
      (occupancy_o == 11'(bhpq_pkg::DEPTH) && out_key_o == '0 && out_payload_o == '0))
    else $error("full status with wrong result");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == bhpq_pkg::ST_EMPTY) |->
      (occupancy_o == '0 && out_key_o == '0 && out_payload_o == '0))
    else $error("empty status with wrong result");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(status_o) && $stable(out_key_o) && $stable(occupancy_o)))
    else $error("stalled result changed");

endmodule

bind binary_heap_priority_queue_unit bhpq_checker u_bhpq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .out_key_o     (out_key_o),
  .out_payload_o (out_payload_o),
  .occupancy_o   (occupancy_o)
);
`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the binary heap priority queue unit. A software heap
// mirrors the entry store, gives the status, removed entry and occupancy for
// every accepted request, and each returned response is checked against the
// oldest outstanding prediction. Stimulus covers the edge cases, a fill past
// full and random mixes under both orderings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bhpq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic                    func;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } request_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    func_i;
  logic [31:0]             key_i;
  logic [15:0]             payload_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [1:0]              status_o;
  logic [31:0]             out_key_o;
  logic [15:0]             out_payload_o;
  logic [10:0]             occupancy_o;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [PADDR_W-1:0]      paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;

  binary_heap_priority_queue_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .key_i         (key_i),
    .payload_i     (payload_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .out_key_o     (out_key_o),
    .out_payload_o (out_payload_o),
    .occupancy_o   (occupancy_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // mirrored heap
  logic [KEY_BITS-1:0]     heap_key [DEPTH];
  logic [PAYLOAD_BITS-1:0] heap_pay [DEPTH];
  int unsigned             heap_count;
  logic                    order_max;

  request_t    pending_requests[$];
  result_t     due_results[$];
  request_t    drive_req;
  result_t     got_result;
  result_t     want_result;
  logic        req_taken;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned requests_issued;
  int unsigned results_seen;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned n_insert;
  int unsigned n_remove;
  int unsigned n_full;
  int unsigned n_empty;
  int unsigned peak_occupancy;

  function automatic logic ranks_above(logic [KEY_BITS-1:0] a, logic [KEY_BITS-1:0] b);
    return order_max ? (a > b) : (a < b);
  endfunction

  function automatic void swap_entries(int unsigned a, int unsigned b);
    logic [KEY_BITS-1:0]     tk;
    logic [PAYLOAD_BITS-1:0] tp;
    tk = heap_key[a];
    tp = heap_pay[a];
    heap_key[a] = heap_key[b];
    heap_pay[a] = heap_pay[b];
    heap_key[b] = tk;
    heap_pay[b] = tp;
  endfunction

  function automatic result_t heap_apply(logic f, logic [KEY_BITS-1:0] k,
                                         logic [PAYLOAD_BITS-1:0] p);
    result_t     r;
    int unsigned i;
    int unsigned lc;
    int unsigned rc;
    int unsigned pick;
    logic        settled;
    r = '0;
    r.status = ST_OK;
    if (f == FUNC_INSERT) begin
      if (heap_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        i = heap_count;
        heap_key[i] = k;
        heap_pay[i] = p;
        heap_count++;
        while (i > 0 && ranks_above(heap_key[i], heap_key[(i - 1) >> 1])) begin
          swap_entries(i, (i - 1) >> 1);
          i = (i - 1) >> 1;
        end
      end
    end else begin
      if (heap_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.key = heap_key[0];
        r.payload = heap_pay[0];
        heap_count--;
        heap_key[0] = heap_key[heap_count];
        heap_pay[0] = heap_pay[heap_count];
        i = 0;
        settled = 1'b0;
        while (!settled) begin
          lc = 2 * i + 1;
          rc = lc + 1;
          if (lc >= heap_count) begin
            settled = 1'b1;
          end else begin
            if (rc >= heap_count) pick = lc;
            else pick = ranks_above(heap_key[lc], heap_key[rc]) ? lc : rc;
            if (ranks_above(heap_key[pick], heap_key[i])) begin
              swap_entries(i, pick);
              i = pick;
            end else begin
              settled = 1'b1;
            end
          end
        end
      end
    end
    r.occupancy = CNT_W'(heap_count);
    return r;
  endfunction

  function automatic logic [KEY_BITS-1:0] pick_key();
    case ($urandom_range(3))
      0: return KEY_BITS'($urandom_range(15));
      1: begin
        case ($urandom_range(3))
          0: return '0;
          1: return '1;
          2: return 32'h8000_0000;
          default: return 32'h7fff_ffff;
        endcase
      end
      default: return KEY_BITS'($urandom);
    endcase
  endfunction

  task automatic push_request(logic f, logic [KEY_BITS-1:0] k, logic [PAYLOAD_BITS-1:0] p);
    request_t rq;
    rq.func = f;
    rq.key = k;
    rq.payload = p;
    pending_requests.push_back(rq);
    requests_issued++;
  endtask

  task automatic push_random(int unsigned count, int unsigned insert_pct);
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(99) < insert_pct)
        push_request(FUNC_INSERT, pick_key(), PAYLOAD_BITS'($urandom));
      else
        push_request(FUNC_REMOVE, KEY_BITS'($urandom), PAYLOAD_BITS'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (results_seen < requests_issued) @(negedge clk_i);
  endtask

  task automatic write_order(logic v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(REG_MAX_FIRST));
    pwdata  <= {31'b0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    order_max = v;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
  end
  always #2 clk_i = ~clk_i;

  // request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      out_ready_i <= 1'b0;
    end else begin
      if (!in_valid_i || req_taken) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          drive_req = pending_requests.pop_front();
          in_valid_i <= 1'b1;
          func_i     <= drive_req.func;
          key_i      <= drive_req.key;
          payload_i  <= drive_req.payload;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: check responses, then predict accepted requests
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        got_result.status    = status_o;
        got_result.key       = out_key_o;
        got_result.payload   = out_payload_o;
        got_result.occupancy = occupancy_o;
        if (due_results.size() == 0) begin
          $error("unexpected response: status %0d key %h", status_o, out_key_o);
          error_count++;
        end else begin
          want_result = due_results.pop_front();
          if (got_result.status !== want_result.status) begin
            $error("status: expected %0d, got %0d", want_result.status, got_result.status);
            error_count++;
          end
          if (got_result.key !== want_result.key) begin
            $error("out_key: expected %h, got %h", want_result.key, got_result.key);
            error_count++;
          end
          if (got_result.payload !== want_result.payload) begin
            $error("out_payload: expected %h, got %h", want_result.payload,
                   got_result.payload);
            error_count++;
          end
          if (got_result.occupancy !== want_result.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want_result.occupancy,
                   got_result.occupancy);
            error_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        want_result = heap_apply(func_i, key_i, payload_i);
        due_results.push_back(want_result);
        if (func_i == FUNC_INSERT) n_insert++;
        else n_remove++;
        if (want_result.status == ST_FULL) n_full++;
        if (want_result.status == ST_EMPTY) n_empty++;
        if (heap_count > peak_occupancy) peak_occupancy = heap_count;
      end
      req_taken <= in_valid_i && in_ready_o;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    func_i = FUNC_INSERT;
    key_i = '0;
    payload_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    heap_count = 0;
    order_max = 1'b0;
    requests_issued = 0;
    results_seen = 0;
    error_count = 0;
    cycle_count = 0;
    n_insert = 0;
    n_remove = 0;
    n_full = 0;
    n_empty = 0;
    peak_occupancy = 0;
    send_idle_pct = 23;
    recv_idle_pct = 85;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // edge cases, smallest key first from reset
    push_request(FUNC_REMOVE, '1, '1);
    push_request(FUNC_INSERT, 32'h0000_0005, 16'h0001);
    push_request(FUNC_INSERT, 32'hffff_ffff, 16'hffff);
    push_request(FUNC_INSERT, 32'h0000_0000, 16'h0000);
    push_request(FUNC_INSERT, 32'h8000_0000, 16'h8000);
    push_request(FUNC_INSERT, 32'h7fff_ffff, 16'h7fff);
    push_request(FUNC_INSERT, 32'h0000_0005, 16'h0002);
    push_request(FUNC_INSERT, 32'h0000_0005, 16'h0003);
    push_request(FUNC_INSERT, 32'h0000_0005, 16'h0004);
    repeat (9) push_request(FUNC_REMOVE, '0, '0);
    // equal children below a larger moved entry
    push_request(FUNC_INSERT, 32'd1, 16'h00a1);
    push_request(FUNC_INSERT, 32'd5, 16'h00a5);
    push_request(FUNC_INSERT, 32'd5, 16'h00b5);
    push_request(FUNC_INSERT, 32'd9, 16'h00a9);
    repeat (4) push_request(FUNC_REMOVE, '0, '0);
    wait_drained();

    push_random(200, 60);
    wait_drained();

    // flip ordering with entries held, then fill past full
    write_order(1'b1);
    send_idle_pct = 85;
    recv_idle_pct = 23;
    for (int unsigned n = 0; n < DEPTH - heap_count + 4; n++)
      push_request(FUNC_INSERT, pick_key(), PAYLOAD_BITS'($urandom));
    push_random(60, 50);
    wait_drained();

    write_order(1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random(150, 35);
    wait_drained();

    repeat (32) @(negedge clk_i);
    $display("summary: %0d inserts (%0d rejected full), %0d removes (%0d on empty)",
             n_insert, n_full, n_remove, n_empty);
    $display("summary: %0d responses checked, peak occupancy %0d, %0d mismatches",
             results_seen, peak_occupancy, error_count);
    if (error_count == 0 && due_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/bhpq_pkg.sv
sv/bhpq_ram.sv
sv/bhpq_sift.sv
sv/binary_heap_priority_queue_unit.sv
sv/bhpq_checker.sv
tb/testbench.sv
